// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/core/tbsc_pkg.sv -----
// Shared types, constants and the round function of the Trivium byte cipher.
package tbsc_pkg;

	localparam int STATE_BITS    = 288;
	localparam int KEY_BITS      = 80;
	localparam int IV_POS        = 93;
	localparam int THIRD_POS     = 177;
	localparam int WARMUP_PASSES = 4;
	localparam int BYTE_BITS     = 8;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_ADDR_W    = 2;
	localparam int HIGH_W        = KEY_BITS - CFG_DATA_W;

	// Eight rounds per cycle; number of eight-round warm-up steps
	localparam int WARM_CYCLES = WARMUP_PASSES * STATE_BITS / BYTE_BITS;
	localparam int WCNT_W      = $clog2(WARM_CYCLES);

	typedef logic [STATE_BITS-1:0] state_t;

	// Configuration register indexes
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_KEY_LOW  = 2'd0,
		REG_KEY_HIGH = 2'd1,
		REG_IV_LOW   = 2'd2,
		REG_IV_HIGH  = 2'd3
	} cfg_reg_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WARM,
		ST_EMIT
	} ctrl_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;       // reload state from key and IV, capture input byte
		logic warm;       // advance eight rounds, no output
		logic step_in;    // advance, result = input byte ^ keystream
		logic step_held;  // advance, result = captured byte ^ keystream
	} dp_cmd_t;

	typedef struct packed {
		state_t               st;
		logic [BYTE_BITS-1:0] ks;
	} rounds_t;

	// Eight Trivium rounds; keystream bit k lands in ks[k]
	function automatic rounds_t tri_rounds8(input state_t s_in);
		rounds_t r;
		state_t  s;
		logic    a, b, c;
		s    = s_in;
		r.ks = '0;
		for (int k = 0; k < BYTE_BITS; k++) begin
			a = s[65] ^ s[92];
			b = s[161] ^ s[176];
			c = s[242] ^ s[287];
			r.ks[k] = a ^ b ^ c;
			a = a ^ (s[90] & s[91]) ^ s[170];
			b = b ^ (s[174] & s[175]) ^ s[263];
			c = c ^ (s[285] & s[286]) ^ s[68];
			s = {s[STATE_BITS-2:0], c};
			s[IV_POS]    = a;
			s[THIRD_POS] = b;
		end
		r.st = s;
		return r;
	endfunction

endpackage

// ----- rtl/core/tbsc_datapath.sv -----
// Datapath: key/IV registers, cipher state, eight-round step and result register.
module tbsc_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [tbsc_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [tbsc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  tbsc_pkg::dp_cmd_t                   cmd,
	input  logic [tbsc_pkg::BYTE_BITS-1:0]      data_byte,
	output logic [tbsc_pkg::BYTE_BITS-1:0]      result_byte
);

	logic [tbsc_pkg::CFG_DATA_W-1:0] key_low_q, iv_low_q;
	logic [tbsc_pkg::HIGH_W-1:0]     key_high_q, iv_high_q;
	tbsc_pkg::state_t                state_q, load_st;
	tbsc_pkg::rounds_t               rnd;
	logic [tbsc_pkg::BYTE_BITS-1:0]  held_q, result_q, src_byte;
	logic                            advance;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
			iv_low_q   <= '0;
			iv_high_q  <= '0;
		end else if (cfg_wen) begin
			unique case (tbsc_pkg::cfg_reg_t'(cfg_addr))
				tbsc_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data;
				tbsc_pkg::REG_KEY_HIGH: key_high_q <= cfg_data[tbsc_pkg::HIGH_W-1:0];
				tbsc_pkg::REG_IV_LOW:   iv_low_q   <= cfg_data;
				tbsc_pkg::REG_IV_HIGH:  iv_high_q  <= cfg_data[tbsc_pkg::HIGH_W-1:0];
				default: ;
			endcase
		end
	end

	// Load pattern: key low, IV from bit 93, ones in the top three bits
	always_comb begin
		load_st = '0;
		load_st[tbsc_pkg::KEY_BITS-1:0] = {key_high_q, key_low_q};
		load_st[tbsc_pkg::IV_POS +: tbsc_pkg::KEY_BITS] = {iv_high_q, iv_low_q};
		load_st[tbsc_pkg::STATE_BITS-1 -: 3] = 3'b111;
	end

	assign rnd     = tbsc_pkg::tri_rounds8(state_q);
	assign advance = cmd.warm | cmd.step_in | cmd.step_held;

	// Cipher state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (cmd.load) begin
			state_q <= load_st;
		end else if (advance) begin
			state_q <= rnd.st;
		end
	end

	// Byte captured at message start, combined after warm-up
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			held_q <= data_byte;
		end
	end

	assign src_byte = cmd.step_held ? held_q : data_byte;

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.step_in || cmd.step_held) begin
			result_q <= src_byte ^ rnd.ks;
		end
	end

	assign result_byte = result_q;

endmodule

// ----- rtl/core/tbsc_ctrl.sv -----
// Controller: accepts bytes, sequences reload and warm-up, owns the output valid.
module tbsc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic               new_message,
	output logic               m_tvalid,
	input  logic               m_tready,
	output tbsc_pkg::dp_cmd_t  cmd
);

	tbsc_pkg::ctrl_state_t       state_q, state_d;
	logic [tbsc_pkg::WCNT_W-1:0] cnt_q, cnt_d;
	logic                        out_valid_q, out_free, out_load, accept;

	assign out_free = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// State, counter and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tbsc_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		s_tready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			tbsc_pkg::ST_IDLE: begin
				s_tready = out_free;
				if (accept) begin
					if (new_message) begin
						cmd.load = 1'b1;
						cnt_d    = '0;
						state_d  = tbsc_pkg::ST_WARM;
					end else begin
						cmd.step_in = 1'b1;
						out_load    = 1'b1;
					end
				end
			end
			tbsc_pkg::ST_WARM: begin
				cmd.warm = 1'b1;
				cnt_d    = cnt_q + 1'b1;
				if (cnt_q == tbsc_pkg::WCNT_W'(tbsc_pkg::WARM_CYCLES - 1)) begin
					state_d = tbsc_pkg::ST_EMIT;
				end
			end
			tbsc_pkg::ST_EMIT: begin
				if (out_free) begin
					cmd.step_held = 1'b1;
					out_load      = 1'b1;
					state_d       = tbsc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tbsc_pkg::ST_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

// ----- rtl/core/trivium_byte_stream_cipher.sv -----
// Top level of the Trivium byte stream cipher.
//
//  Channel   Signals                         Content
//  input     s_tvalid s_tready s_tdata s_tuser  data byte, new-message flag
//  output    m_tvalid m_tready m_tdata          data byte ^ keystream byte
//  config    cfg_wen cfg_addr cfg_data          key_low, key_high, iv_low, iv_high
//
// A byte without the new-message flag needs no warm-up: eight rounds are unrolled
// in the datapath, so one byte per cycle is sustained while the output is drained.
// A byte with the flag is loaded, then the warm-up runs, then its result is emitted.
// Reset clears the cipher state and the key/IV registers to zero.
// The result register holds while m_tready is low; input is taken only when it
// is empty or being drained in the same cycle.
module trivium_byte_stream_cipher (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  logic [tbsc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [tbsc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] data_byte
	input  logic                            s_tuser,   // [0] new_message
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata    // [7:0] result_byte
);

	tbsc_pkg::dp_cmd_t cmd;

	tbsc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.new_message (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.cmd         (cmd)
	);

	tbsc_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_addr    (cfg_addr),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.data_byte   (s_tdata),
		.result_byte (m_tdata)
	);

endmodule

// ----- rtl/core/tbsc_checker.sv -----
// Port-level checker for the Trivium byte cipher, bound to the top level.
`include "assert_macros.svh"

module tbsc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       s_tuser,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata
);

	// A plain byte yields a result on the next cycle
	`ASSERT_NEXT(a_plain_result, s_tvalid && s_tready && !s_tuser, m_tvalid)
	// A message start blocks input during warm-up
	`ASSERT_NEXT(a_warm_stall, s_tvalid && s_tready && s_tuser, !s_tready)
	// Input is taken only when the result register can move on
	`ASSERT_IMPL(a_ready_free, s_tready, !m_tvalid || m_tready)
	// Stalled result holds
	`ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind trivium_byte_stream_cipher tbsc_checker u_tbsc_checker (.*);

// ----- dv/testbench.sv -----
// Self-checking testbench for the Trivium byte cipher: random streams against a predictor.
module testbench;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       new_message;
	} stream_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [tbsc_pkg::CFG_ADDR_W-1:0] cfg_addr = tbsc_pkg::REG_KEY_LOW;
	logic [tbsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;   // [7:0] data_byte
	logic s_tuser = 1'b0;       // [0] new_message
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;        // [7:0] result_byte

	trivium_byte_stream_cipher uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	// Predictor copy of the cipher state and the key/IV registers
	logic [tbsc_pkg::STATE_BITS-1:0] cipher_bits = '0;
	logic [tbsc_pkg::KEY_BITS-1:0]   key_shadow = '0;
	logic [tbsc_pkg::KEY_BITS-1:0]   iv_shadow = '0;

	stream_item_t pending_items[$];
	logic [7:0]   expected_bytes[$];
	stream_item_t cur_item;
	bit           in_taken = 1'b0;
	bit           calm = 1'b0;
	int           fail_count = 0;

	// One Trivium round on the shadow state, returns the keystream bit
	function automatic logic next_keystream_bit();
		logic a, b, c, z;
		a = cipher_bits[65] ^ cipher_bits[92];
		b = cipher_bits[161] ^ cipher_bits[176];
		c = cipher_bits[242] ^ cipher_bits[287];
		z = a ^ b ^ c;
		a = a ^ (cipher_bits[90] & cipher_bits[91]) ^ cipher_bits[170];
		b = b ^ (cipher_bits[174] & cipher_bits[175]) ^ cipher_bits[263];
		c = c ^ (cipher_bits[285] & cipher_bits[286]) ^ cipher_bits[68];
		cipher_bits = {cipher_bits[tbsc_pkg::STATE_BITS-2:0], c};
		cipher_bits[tbsc_pkg::IV_POS] = a;
		cipher_bits[tbsc_pkg::THIRD_POS] = b;
		return z;
	endfunction

	// Load key and IV, set the top three bits, then warm up
	function automatic void reload_cipher();
		logic dummy;
		cipher_bits = '0;
		for (int i = 0; i < tbsc_pkg::KEY_BITS; i++) begin
			cipher_bits[i] = key_shadow[i];
			cipher_bits[i + tbsc_pkg::IV_POS] = iv_shadow[i];
		end
		cipher_bits[285] = 1'b1;
		cipher_bits[286] = 1'b1;
		cipher_bits[287] = 1'b1;
		for (int i = 0; i < tbsc_pkg::WARMUP_PASSES * tbsc_pkg::STATE_BITS; i++)
			dummy = next_keystream_bit();
	endfunction

	function automatic logic [7:0] predict_result_byte(stream_item_t it);
		logic [7:0] ks;
		if (it.new_message)
			reload_cipher();
		for (int k = 0; k < 8; k++)
			ks[k] = next_keystream_bit();
		return it.data_byte ^ ks;
	endfunction

	// Register write on the config port; the shadow follows at once since the block is idle
	task automatic write_cipher_reg(tbsc_pkg::cfg_reg_t idx, logic [63:0] val);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		case (idx)
			tbsc_pkg::REG_KEY_LOW:  key_shadow[63:0] = val;
			tbsc_pkg::REG_KEY_HIGH: key_shadow[79:64] = val[15:0];
			tbsc_pkg::REG_IV_LOW:   iv_shadow[63:0] = val;
			tbsc_pkg::REG_IV_HIGH:  iv_shadow[79:64] = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic queue_item(logic [7:0] data, logic reload);
		stream_item_t it;
		it.data_byte = data;
		it.new_message = reload;
		pending_items.push_back(it);
	endtask

	// Queue one message of random bytes; the first carries the reload flag if asked
	task automatic queue_message(int len, bit reload);
		for (int i = 0; i < len; i++)
			queue_item(8'($urandom_range(0, 255)), reload && (i == 0));
	endtask

	// Sender pauses here until all queued bytes have come back; checked at the
	// rising edge, where the pending queue and s_tvalid are settled
	task automatic wait_drained();
		while (pending_items.size() != 0 || s_tvalid || expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	// Register value: zero, all ones, one-hot or random
	function automatic logic [63:0] pick_reg_value();
		logic [63:0] v;
		case ($urandom_range(0, 5))
			0: v = '0;
			1: v = '1;
			2: v = 64'd1 << $urandom_range(0, 63);
			default: v = {$urandom, $urandom};
		endcase
		return v;
	endfunction

	// Driver: note the transfer at the rising edge and predict its result
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			expected_bytes.push_back(predict_result_byte(cur_item));
			in_taken = 1'b1;
		end
	end

	// Driver: present the next pending byte at the falling edge
	always @(negedge clk) begin
		logic hold;
		if (arst_n) begin
			hold = s_tvalid && !in_taken;
			in_taken = 1'b0;
			if (!hold && pending_items.size() != 0 && (calm || $urandom_range(0, 99) >= 13)) begin
				cur_item = pending_items.pop_front();
				s_tdata <= cur_item.data_byte;
				s_tuser <= cur_item.new_message;
				hold = 1'b1;
			end
			s_tvalid <= hold;
			m_tready <= calm || ($urandom_range(0, 99) >= 13);
		end
	end

	// Monitor: compare each output transfer with the oldest expectation
	always @(posedge clk) begin
		logic [7:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_bytes.size() == 0) begin
				$error("result_byte: no result expected, actual %02h", m_tdata);
				fail_count++;
			end else begin
				want = expected_bytes.pop_front();
				if (m_tdata !== want) begin
					$error("result_byte: expected %02h, actual %02h", want, m_tdata);
					fail_count++;
				end
			end
		end
	end

	// Stimulus sequence
	initial begin
		int sent;
		int len;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// Zero state after reset gives a zero keystream; then a reload with all-zero key and IV
		queue_item(8'h00, 1'b0);
		queue_item(8'hFF, 1'b0);
		queue_item(8'hA5, 1'b0);
		queue_item(8'h00, 1'b1);
		queue_item(8'hFF, 1'b0);
		queue_item(8'h5A, 1'b0);
		wait_drained();

		// All-ones registers, upper bits of the high words masked off
		write_cipher_reg(tbsc_pkg::REG_KEY_LOW, '1);
		write_cipher_reg(tbsc_pkg::REG_KEY_HIGH, '1);
		write_cipher_reg(tbsc_pkg::REG_IV_LOW, '1);
		write_cipher_reg(tbsc_pkg::REG_IV_HIGH, '1);
		queue_item(8'h00, 1'b1);
		queue_item(8'hFF, 1'b0);
		queue_item(8'h5A, 1'b0);
		// back-to-back reloads: a one-byte message, then a two-byte one
		queue_item(8'h3C, 1'b1);
		queue_item(8'hC3, 1'b1);
		queue_item(8'h81, 1'b0);
		wait_drained();

		// New key and IV must not touch the running stream until the next reload
		write_cipher_reg(tbsc_pkg::REG_KEY_LOW, 64'h0123_4567_89AB_CDEF);
		write_cipher_reg(tbsc_pkg::REG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_1357);
		write_cipher_reg(tbsc_pkg::REG_IV_LOW, 64'h8000_0000_0000_0001);
		write_cipher_reg(tbsc_pkg::REG_IV_HIGH, 64'h0000_0000_0000_8001);
		queue_item(8'h12, 1'b0);
		queue_item(8'h34, 1'b0);
		queue_item(8'h56, 1'b0);
		queue_item(8'h78, 1'b1);
		queue_item(8'h9A, 1'b0);
		queue_item(8'hBC, 1'b0);
		wait_drained();

		// Random phases: mostly messages that start with a reload
		for (int phase = 0; phase < 6; phase++) begin
			calm = (phase == 2);
			write_cipher_reg(tbsc_pkg::REG_KEY_LOW, pick_reg_value());
			if ($urandom_range(0, 3) != 0)
				write_cipher_reg(tbsc_pkg::REG_KEY_HIGH, pick_reg_value());
			if ($urandom_range(0, 3) != 0)
				write_cipher_reg(tbsc_pkg::REG_IV_LOW, pick_reg_value());
			write_cipher_reg(tbsc_pkg::REG_IV_HIGH, pick_reg_value());
			sent = 0;
			while (sent < 130) begin
				len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 24) : $urandom_range(25, 160);
				queue_message(len, $urandom_range(0, 11) != 0);
				sent += len;
			end
			wait_drained();
		end
		calm = 1'b0;

		repeat (200) @(negedge clk);
		if (expected_bytes.size() != 0) begin
			$error("result_byte: %0d results never arrived", expected_bytes.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Watchdog
	initial begin
		#(20 * 2000000);
		$display("Test completed with failures");
		$finish;
	end

endmodule
